[rtl/core/cdq_pkg.sv]
// Package for the circular deque: operation and status codes,
// controller-to-datapath command and status structs. No dependencies.
package cdq_pkg;

    localparam int OP_W = 2;
    localparam int ST_W = 2;
    localparam int WORD_W = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch incoming item
        logic exec;     // perform the operation on the store
        logic load;     // move the result into the output register
    } t_cmd;

    // datapath -> top (observed state)
    typedef struct packed {
        logic empty;
        logic full;
        logic at_origin;  // head and tail both at entry 0
    } t_stat;

endpackage

[rtl/core/cdq_dpath.sv]
// Datapath of the circular deque: item latch, head/tail indices, entry
// store, read register and output register. Uses cdq_pkg.
module cdq_dpath #(
    parameter int DEPTH = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cdq_pkg::t_cmd               i_cmd,
    input  logic [cdq_pkg::OP_W-1:0]    i_op,
    input  logic [cdq_pkg::WORD_W-1:0]  i_value,
    output logic [cdq_pkg::WORD_W-1:0]  o_data,
    output logic [cdq_pkg::ST_W-1:0]    o_status,
    output cdq_pkg::t_stat              o_stat
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WORD_W-1:0] r_mem [DEPTH];

    logic [OP_W-1:0]   r_op;
    logic [WORD_W-1:0] r_value;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic              r_empty, n_empty;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_pop_ok, n_pop_ok;
    logic [ST_W-1:0]   r_res_st, n_res_st;
    logic [WORD_W-1:0] r_out_data;
    logic [ST_W-1:0]   r_out_st;

    logic [AW-1:0] head_nx, head_pv, tail_nx, tail_pv;
    logic          full;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;

    assign head_nx = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign head_pv = (r_head == '0) ? LAST : r_head - 1'b1;
    assign tail_nx = (r_tail == LAST) ? '0 : r_tail + 1'b1;
    assign tail_pv = (r_tail == '0) ? LAST : r_tail - 1'b1;
    assign full    = !r_empty && (r_head == tail_nx);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_pop_ok = 1'b0;
        n_res_st = ST_DONE;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = '0;
        raddr    = (r_op == OP_POP_FRONT) ? r_head : r_tail;
        if (!r_op[1]) begin
            if (full) begin
                n_res_st = ST_OVERFLOW;
            end else begin
                we = i_cmd.exec;
                if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    waddr   = '0;
                end else if (r_op == OP_PUSH_FRONT) begin
                    n_head = head_pv;
                    waddr  = head_pv;
                end else begin
                    n_tail = tail_nx;
                    waddr  = tail_nx;
                end
            end
        end else begin
            if (r_empty) begin
                n_res_st = ST_UNDERFLOW;
            end else begin
                re       = i_cmd.exec;
                n_pop_ok = 1'b1;
                if (r_head == r_tail) begin
                    n_empty = 1'b1;
                    n_head  = '0;
                    n_tail  = '0;
                end else if (r_op == OP_POP_FRONT) begin
                    n_head = head_nx;
                end else begin
                    n_tail = tail_pv;
                end
            end
        end
    end

    // entry store: one write or one registered read per operation
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= r_value;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_pop_ok <= n_pop_ok;
            r_res_st <= n_res_st;
        end
        if (i_cmd.load) begin
            r_out_data <= r_pop_ok ? r_rd_data : '0;
            r_out_st   <= r_res_st;
        end
    end

    assign o_data           = r_out_data;
    assign o_status         = r_out_st;
    assign o_stat.empty     = r_empty;
    assign o_stat.full      = full;
    assign o_stat.at_origin = (r_head == '0) && (r_tail == '0);

endmodule

[rtl/core/cdq_ctrl.sv]
// Controller of the circular deque: sequences capture, execute and
// result load, and owns the stream handshakes. Uses cdq_pkg.
module cdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    output logic          o_m_valid,
    input  logic          i_m_ready,
    output cdq_pkg::t_cmd o_cmd
);
    import cdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_m_valid, n_m_valid;
    logic       out_free;

    assign out_free = !r_m_valid || i_m_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_m_valid   = r_m_valid && !i_m_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_m_valid  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

[rtl/core/circular_double_ended_queue_unit.sv]
// Circular double-ended queue over DEPTH 32-bit words. Top level; uses
// cdq_pkg, cdq_ctrl and cdq_dpath.
//
// Each input item carries an operation in tuser (push front, push rear,
// pop front, pop rear) and a push word in tdata; each item gives exactly
// one result item: the popped word in tdata (zero unless a pop succeeded)
// and a status in tuser (done, overflow when a push hits a full deque and
// is dropped, underflow when a pop hits an empty deque). One item is in
// work at a time: accept, then an execute step that updates the indices and
// accesses the single-port entry store, then a load step that moves the
// registered read data into the output register and raises result valid
// together with input ready. The output register decouples the sides: the
// next item is accepted while a result still waits; only a second result
// stalls until the first is taken.
// The store needs no clearing after reset - only pushed entries are read.
module circular_double_ended_queue_unit #(
    parameter int DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] operation
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] popped_value
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import cdq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cdq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (cmd)
    );

    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_op     (i_s_axis_tuser),
        .i_value  (i_s_axis_tdata),
        .o_data   (o_m_axis_tdata),
        .o_status (o_m_axis_tuser),
        .o_stat   (stat)
    );

    // one item in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while an item is in work");

    // an empty deque keeps both indices at entry 0
    a_empty_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.empty |-> stat.at_origin)
        else $error("empty deque with indices off entry 0");

    // failed operations never return data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_DONE)) |-> (o_m_axis_tdata == '0))
        else $error("nonzero data on a failed operation");

    // a deque cannot be full and empty at once
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.full && stat.empty))
        else $error("deque flagged full and empty");

endmodule

[dv/tb.sv]
// Self-checking testbench for circular_double_ended_queue_unit: a directed table
// of deque operations, then random fill/drain/mixed bursts with random idling.
// Depends on cdq_pkg for the operation and status codes.
module tb;
    import cdq_pkg::*;

    localparam int DEPTH      = 128;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int RAND_ITEMS = 1650;
    localparam int STALL_MAX  = 19;
    localparam int IDLE_LIMIT = 200;   // cycles with no item moving on either side
    localparam int TAIL_WAIT  = 8;     // wait after the last result drains, with margin
    localparam int PRINT_MAX  = 40;

    typedef struct packed {
        logic [WORD_W-1:0] popped;
        logic [ST_W-1:0]   status;
    } t_deque_result;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] value;
        logic              typed;   // expected result written in the row
        logic [WORD_W-1:0] popped;
        logic [ST_W-1:0]   status;
    } t_op_row;

    localparam int N_ROWS = 21;

    // directed rows; typed expectations only where obvious
    t_op_row op_table [0:N_ROWS-1] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
        '{OP_POP_REAR,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
        '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
        '{OP_POP_REAR,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_DONE},
        '{OP_POP_FRONT,  32'h1234_5678, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
        '{OP_PUSH_REAR,  32'h8000_0000, 1'b1, 32'h0000_0000, ST_DONE},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
        '{OP_PUSH_REAR,  32'h0000_0000, 1'b0, 32'h0, ST_DONE},
        '{OP_PUSH_FRONT, 32'h0000_0001, 1'b0, 32'h0, ST_DONE},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_DONE},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_DONE},
        '{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_DONE},
        '{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_DONE},
        '{OP_POP_REAR,   32'hA5A5_A5A5, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
        '{OP_PUSH_REAR,  32'h5555_5555, 1'b0, 32'h0, ST_DONE},
        '{OP_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, 32'h0, ST_DONE},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_DONE},
        '{OP_PUSH_FRONT, 32'h1234_5678, 1'b0, 32'h0, ST_DONE},
        '{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_DONE},
        '{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_DONE},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [31:0]       i_s_axis_tdata = '0;   // [31:0] push_value
    logic [1:0]        i_s_axis_tuser = '0;   // [1:0] operation
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [31:0]       o_m_axis_tdata;        // [31:0] popped_value
    logic [1:0]        o_m_axis_tuser;        // [1:0] status

    circular_double_ended_queue_unit #(.DEPTH(DEPTH)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // deque shadow state
    logic [WORD_W-1:0] dq_store [0:DEPTH-1];
    logic [IDX_W-1:0]  dq_head = '0;
    logic [IDX_W-1:0]  dq_tail = '0;
    logic              dq_empty = 1'b1;

    t_deque_result pending_results [$];
    int            fail_count = 0;
    int            idle_cycles = 0;
    bit            tx_quiet = 1'b0;   // sender burst with no gaps
    bit            rx_quiet = 1'b0;   // receiver stretch with no stalls

    function automatic logic [IDX_W-1:0] idx_inc(logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // apply one operation to the shadow deque, return the result it gives
    function automatic t_deque_result deque_apply(logic [OP_W-1:0] op,
                                                  logic [WORD_W-1:0] value);
        t_deque_result r;
        logic          full;
        r.popped = '0;
        r.status = ST_DONE;
        full = !dq_empty && (dq_head == idx_inc(dq_tail));
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
            if (full) begin
                r.status = ST_OVERFLOW;
            end else if (dq_empty) begin
                dq_head = '0;
                dq_tail = '0;
                dq_empty = 1'b0;
                dq_store[0] = value;
            end else if (op == OP_PUSH_FRONT) begin
                dq_head = idx_dec(dq_head);
                dq_store[dq_head] = value;
            end else begin
                dq_tail = idx_inc(dq_tail);
                dq_store[dq_tail] = value;
            end
        end else begin
            if (dq_empty) begin
                r.status = ST_UNDERFLOW;
            end else begin
                r.popped = (op == OP_POP_FRONT) ? dq_store[dq_head] : dq_store[dq_tail];
                if (dq_head == dq_tail) begin
                    // last element gone: indices go back to the origin
                    dq_empty = 1'b1;
                    dq_head = '0;
                    dq_tail = '0;
                end else if (op == OP_POP_FRONT) begin
                    dq_head = idx_inc(dq_head);
                end else begin
                    dq_tail = idx_dec(dq_tail);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (fail_count < PRINT_MAX)
            $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, STALL_MAX);
    endfunction

    // present one item, wait for it to be taken, record what it should give
    task automatic send_item(logic [OP_W-1:0] op, logic [WORD_W-1:0] value,
                             bit typed, t_deque_result typed_res);
        int            gap;
        t_deque_result r;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = deque_apply(op, value);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // hold the input until every outstanding result has drained
    task automatic drain_pause();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls, compare against the oldest expectation
    initial begin : result_side
        int            stall;
        t_deque_result want;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
            stall = draw_gap(rx_quiet);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata !== want.popped)
                    report_mismatch("popped_value", o_m_axis_tdata, want.popped);
                if (o_m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(o_m_axis_tuser), 32'(want.status));
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int            sent;
        int            burst_len;
        int            mode;
        int            push_pct;
        bit            paused;
        bit            is_push;
        logic [OP_W-1:0] op;
        t_deque_result typed_res;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (op_table[k]) begin
            typed_res.popped = op_table[k].popped;
            typed_res.status = op_table[k].status;
            send_item(op_table[k].op, op_table[k].value, op_table[k].typed, typed_res);
        end
        drain_pause();

        // random bursts: fill toward overflow, drain toward underflow, or mixed
        sent = 0;
        paused = 1'b0;
        typed_res = '0;
        while (sent < RAND_ITEMS) begin
            mode = $urandom_range(0, 3);
            push_pct = (mode == 0) ? 88 : (mode == 1) ? 12 : 50;
            tx_quiet = ($urandom_range(0, 3) == 0);
            burst_len = $urandom_range(16, 220);
            if (burst_len > RAND_ITEMS - sent) burst_len = RAND_ITEMS - sent;
            repeat (burst_len) begin
                is_push = ($urandom_range(0, 99) < push_pct);
                op = is_push ? ($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT)
                             : ($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT);
                send_item(op, draw_word(), 1'b0, typed_res);
                sent++;
            end
            if (!paused && sent >= RAND_ITEMS / 2) begin
                drain_pause();
                paused = 1'b1;
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/cdq_pkg.sv
rtl/core/cdq_dpath.sv
rtl/core/cdq_ctrl.sv
rtl/core/circular_double_ended_queue_unit.sv
dv/tb.sv
